// File: hw/rtl/ufs_pkg.sv
package ufs_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = $clog2(NODES);
  localparam int SIZE_W = NODE_W + 1;
  localparam int LINK_W = NODE_W + 2;

  localparam int IN_W   = 24;
  localparam int OUT_W  = 48;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [LINK_W-1:0] link_t;

  // Memory access selected by the controller for the current cycle.
  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_CLEAR,
    MEM_RD_CUR,
    MEM_RD_NEXT,
    MEM_WR_ROOT,
    MEM_WR_WIN,
    MEM_WR_LOSE
  } mem_op_t;

  typedef struct packed {
    mem_op_t mem_op;
    logic    clr_inc;
    logic    load_item;
    logic    walk_b;
    logic    step;
    logic    found;
    logic    sel_b;
    logic    load_out;
  } ufs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rd_is_root;
    logic cur_is_root;
    logic do_union;
    logic out_free;
  } ufs_stat_t;

endpackage

// File: hw/rtl/ufs_ctrl.sv
module ufs_ctrl
  import ufs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ufs_stat_t stat,
  output ufs_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CHK,
    ST_COMP_CHK,
    ST_COMP_WR,
    ST_MERGE_WIN,
    ST_MERGE_LOSE,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   sel_b;
  logic   sel_b_next;

  always_comb begin
    state_next = state;
    sel_b_next = sel_b;
    cmd        = '0;
    cmd.mem_op = MEM_NONE;
    cmd.sel_b  = sel_b;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.mem_op  = MEM_CLEAR;
        cmd.clr_inc = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          sel_b_next    = 1'b0;
          state_next    = ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        cmd.mem_op = MEM_RD_CUR;
        state_next = ST_UP_CHK;
      end
      ST_UP_CHK: begin
        // The read data belongs to the current node; follow its parent link
        // until a root entry shows up.
        if (stat.rd_is_root) begin
          cmd.found  = 1'b1;
          state_next = ST_COMP_CHK;
        end else begin
          cmd.mem_op = MEM_RD_NEXT;
          cmd.step   = 1'b1;
        end
      end
      ST_COMP_CHK: begin
        if (stat.cur_is_root) begin
          if (!sel_b) begin
            cmd.walk_b = 1'b1;
            sel_b_next = 1'b1;
            state_next = ST_UP_RD;
          end else if (stat.do_union) begin
            state_next = ST_MERGE_WIN;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          cmd.mem_op = MEM_RD_CUR;
          state_next = ST_COMP_WR;
        end
      end
      ST_COMP_WR: begin
        cmd.mem_op = MEM_WR_ROOT;
        cmd.step   = 1'b1;
        state_next = ST_COMP_CHK;
      end
      ST_MERGE_WIN: begin
        cmd.mem_op = MEM_WR_WIN;
        state_next = ST_MERGE_LOSE;
      end
      ST_MERGE_LOSE: begin
        cmd.mem_op = MEM_WR_LOSE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sel_b <= 1'b0;
    end else begin
      state <= state_next;
      sel_b <= sel_b_next;
    end
  end

endmodule

// File: hw/rtl/ufs_datapath.sv
module ufs_datapath
  import ufs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ufs_cmd_t         cmd,
  output ufs_stat_t        stat,
  input  logic [IN_W-1:0]  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  // A root entry holds minus its set size, any other entry its parent index.
  link_t mem [NODES];
  link_t rdata;

  node_t clr_cnt;
  logic  merge_r;
  node_t na_r;
  node_t nb_r;
  node_t cur;
  node_t root_r;
  node_t la;
  node_t lb;
  size_t sa;
  size_t sb;

  logic  out_valid_r;
  node_t out_la;
  node_t out_lb;
  logic  out_joined;
  node_t out_root;
  size_t out_size;

  logic  we;
  logic  re;
  node_t waddr;
  node_t raddr;
  link_t wdata;
  link_t neg_rd;
  size_t size_sum;
  logic  b_wins;
  node_t winner;
  node_t loser;
  logic  joined;

  assign neg_rd   = -rdata;
  assign size_sum = sa + sb;
  assign b_wins   = (sb > sa);
  assign winner   = b_wins ? lb : la;
  assign loser    = b_wins ? la : lb;
  assign joined   = (la == lb);

  assign stat.clr_last    = (clr_cnt == node_t'(NODES - 1));
  assign stat.rd_is_root  = rdata[LINK_W-1];
  assign stat.cur_is_root = (cur == root_r);
  assign stat.do_union    = merge_r && !joined;
  assign stat.out_free    = !out_valid_r || out_ready;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cur;
    raddr = cur;
    wdata = '1;
    unique case (cmd.mem_op)
      MEM_NONE: begin
      end
      MEM_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '1;
      end
      MEM_RD_CUR: begin
        re = 1'b1;
      end
      MEM_RD_NEXT: begin
        re    = 1'b1;
        raddr = rdata[NODE_W-1:0];
      end
      MEM_WR_ROOT: begin
        we    = 1'b1;
        wdata = LINK_W'(root_r);
      end
      MEM_WR_WIN: begin
        we    = 1'b1;
        waddr = winner;
        wdata = link_t'(0) - LINK_W'(size_sum);
      end
      MEM_WR_LOSE: begin
        we    = 1'b1;
        waddr = loser;
        wdata = LINK_W'(winner);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_inc) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      merge_r <= in_data[0];
      na_r    <= in_data[NODE_W:1];
      nb_r    <= in_data[2*NODE_W:NODE_W+1];
      cur     <= in_data[NODE_W:1];
    end else if (cmd.walk_b) begin
      cur <= nb_r;
    end else if (cmd.found) begin
      // Restart from the looked-up node to relink its path to the root.
      cur    <= cmd.sel_b ? nb_r : na_r;
      root_r <= cur;
    end else if (cmd.step) begin
      cur <= rdata[NODE_W-1:0];
    end

    if (cmd.found) begin
      if (cmd.sel_b) begin
        lb <= cur;
        sb <= neg_rd[SIZE_W-1:0];
      end else begin
        la <= cur;
        sa <= neg_rd[SIZE_W-1:0];
      end
    end

    if (cmd.load_out) begin
      out_la     <= la;
      out_lb     <= lb;
      out_joined <= joined;
      out_root   <= stat.do_union ? winner : la;
      out_size   <= stat.do_union ? size_sum : sa;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {(OUT_W - 1 - 3 * NODE_W - SIZE_W)'(0), out_size, out_root, out_joined,
                      out_lb, out_la};

endmodule

// File: hw/rtl/union_find_by_size.sv
// Order of work per item: walk node_a's parent links up to its root, relink that path
// to the root, then do the same for node_b; on a merge, write the summed size to the
// winning root (node_b's only if its set is strictly larger) and link the other root to
// it. One item at a time; the next is taken only after the result is in the output register.
// Reset: synchronous; a clearing pass writes every entry to a singleton,
// during which s_tready stays low.
module union_find_by_size
  import ufs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // command, node_a, node_b
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // leader_a, leader_b, joined_before, root_after, group_size
);

  ufs_cmd_t  cmd;
  ufs_stat_t stat;

  ufs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ufs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

`ifndef SYNTHESIS
  // Only one item is in flight, so the input closes right after a transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in progress");

  a_joined_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20] == (m_tdata[9:0] == m_tdata[19:10])))
    else $error("joined_before disagrees with the leaders");

  a_root_is_leader: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:21] == m_tdata[9:0]) || (m_tdata[30:21] == m_tdata[19:10]))
    else $error("root_after is neither leader");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[41:31] != 11'd0))
    else $error("group_size is zero");
`endif

endmodule
